FILE: design/mivd_pkg.sv
// Shared types, constants and sizing for the Manchester interval word decoder.
package mivd_pkg;

   // Number of data bits in one word.
   localparam int WORD_BITS = 16;

   // Width of the data bit counter; it must hold WORD_BITS itself.
   localparam int BitCntW = $clog2(WORD_BITS + 1);
   localparam logic [BitCntW-1:0] WordBitsCnt = BitCntW'(WORD_BITS);

   // Widths of the fixed fields.
   localparam int IntervalW = 10;
   localparam int WordOutW  = 16;

   // Interval class limits, in percent of one bit period.
   localparam logic [IntervalW-1:0] LenMinExcl   = IntervalW'(25);
   localparam logic [IntervalW-1:0] LenMax       = IntervalW'(225);
   localparam logic [IntervalW-1:0] HalfMax      = IntervalW'(75);
   localparam logic [IntervalW-1:0] FullMax      = IntervalW'(125);
   localparam logic [IntervalW-1:0] SyncShortMax = IntervalW'(175);

   // Status codes reported with each result.
   typedef enum logic [2:0] {
      ST_WAIT       = 3'd0,
      ST_SYNC       = 3'd1,
      ST_HANDLE     = 3'd2,
      ST_CHECK      = 3'd3,
      ST_READY      = 3'd4,
      ST_ERR_LEN    = 3'd5,
      ST_ERR_STRUCT = 3'd6
   } status_code_type;

   // One result as it leaves the decode logic.
   typedef struct packed {
      status_code_type     status;
      logic [WordOutW-1:0] word_out;
      logic                is_command;
   } result_type;

endpackage

FILE: design/mivd_req_if.sv
// Request channel: one edge-to-edge interval per request.
interface mivd_req_if;
   logic                           valid;
   logic                           ready;
   logic [mivd_pkg::IntervalW-1:0] interval_pct;

   modport source (output valid, output interval_pct, input ready);
   modport sink   (input valid, input interval_pct, output ready);
endinterface

FILE: design/mivd_rsp_if.sv
// Result channel: status, last completed word and its type.
interface mivd_rsp_if;
   logic                          valid;
   logic                          ready;
   mivd_pkg::status_code_type     status;
   logic [mivd_pkg::WordOutW-1:0] word_out;
   logic                          is_command;

   modport source (output valid, output status, output word_out, output is_command,
                   input ready);
   modport sink   (input valid, input status, input word_out, input is_command,
                   output ready);
endinterface

FILE: design/mivd_csr_if.sv
// Configuration write channel carrying the parity seed.
interface mivd_csr_if;
   logic valid;
   logic ready;
   logic parity_seed;

   modport source (output valid, output parity_seed, input ready);
   modport sink   (input valid, input parity_seed, output ready);
endinterface

FILE: design/mivd_core.sv
// Decoder state and the single-pass interval classification and word assembly.
module mivd_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step_en,
   input  logic [mivd_pkg::IntervalW-1:0]      interval_pct,
   input  logic                                parity_seed,
   output mivd_pkg::result_type                result
);

   localparam int W  = mivd_pkg::WORD_BITS;
   localparam int CW = mivd_pkg::BitCntW;

   // Decoder state.
   logic          line_level_ff,   line_level_in;
   logic [CW-1:0] bit_count_ff,    bit_count_in;
   logic [1:0]    half_count_ff,   half_count_in;
   logic [W-1:0]  shift_word_ff,   shift_word_in;
   logic          type_pending_ff, type_pending_in;
   logic          parity_acc_ff,   parity_acc_in;
   logic          in_word_ff,      in_word_in;
   logic [W-1:0]  held_word_ff,    held_word_in;
   logic          held_type_ff,    held_type_in;

   logic [2:0]    halves;
   logic          level_t;
   logic [W:0]    shifted;
   logic [W+mivd_pkg::WordOutW-1:0] held_ext;
   mivd_pkg::status_code_type status;

   // Classify the interval and work out the next state and the status.
   always_comb begin
      level_t         = ~line_level_ff;
      line_level_in   = level_t;
      bit_count_in    = bit_count_ff;
      half_count_in   = half_count_ff;
      shift_word_in   = shift_word_ff;
      type_pending_in = type_pending_ff;
      parity_acc_in   = parity_acc_ff;
      in_word_in      = in_word_ff;
      held_word_in    = held_word_ff;
      held_type_in    = held_type_ff;
      halves          = 3'd0;
      shifted         = {shift_word_ff, level_t};
      status          = mivd_pkg::ST_WAIT;

      if (interval_pct <= mivd_pkg::LenMinExcl || interval_pct > mivd_pkg::LenMax) begin
         // Out of range: drop any word in progress.
         bit_count_in  = '0;
         half_count_in = 2'd0;
         in_word_in    = 1'b0;
         status        = mivd_pkg::ST_ERR_LEN;
      end else begin
         if (interval_pct <= mivd_pkg::HalfMax) begin
            halves = {1'b0, half_count_ff} + 3'd1;
         end else if (interval_pct <= mivd_pkg::FullMax) begin
            halves = {1'b0, half_count_ff} + 3'd2;
         end else begin
            // Sync pulse opens a new word.
            in_word_in      = 1'b1;
            shift_word_in   = '0;
            parity_acc_in   = parity_seed;
            bit_count_in    = '0;
            halves          = (interval_pct <= mivd_pkg::SyncShortMax) ? 3'd1 : 3'd2;
            type_pending_in = ~level_t;
         end

         if (halves >= 3'd3) begin
            // Three or more half bits in a row break the Manchester structure.
            bit_count_in  = '0;
            half_count_in = 2'd0;
            in_word_in    = 1'b0;
            status        = mivd_pkg::ST_ERR_STRUCT;
         end else begin
            half_count_in = halves[1:0];
            if (!in_word_in) begin
               status = mivd_pkg::ST_WAIT;
            end else if (halves[1:0] == 2'd2 && bit_count_in >= mivd_pkg::WordBitsCnt) begin
               // Final half: complete the word and fix a reversed polarity.
               held_word_in    = shift_word_in;
               held_type_in    = type_pending_in;
               shift_word_in   = '0;
               type_pending_in = 1'b0;
               bit_count_in    = '0;
               half_count_in   = 2'd0;
               in_word_in      = 1'b0;
               if (level_t != parity_acc_in) begin
                  line_level_in = ~level_t;
                  held_word_in  = ~held_word_in;
                  held_type_in  = ~held_type_in;
               end
               status = mivd_pkg::ST_READY;
            end else begin
               if (halves[1:0] == 2'd2) begin
                  // A full bit cell: shift in the level at its end.
                  shift_word_in = shifted[W-1:0];
                  parity_acc_in = parity_acc_in ^ level_t;
                  bit_count_in  = bit_count_in + CW'(1);
                  half_count_in = 2'd0;
               end
               status = (bit_count_in < mivd_pkg::WordBitsCnt) ? mivd_pkg::ST_HANDLE
                                                               : mivd_pkg::ST_CHECK;
            end
         end
      end
   end

   // Result fields follow the updated held word and type.
   assign held_ext          = {{mivd_pkg::WordOutW{1'b0}}, held_word_in};
   assign result.status     = status;
   assign result.word_out   = held_ext[mivd_pkg::WordOutW-1:0];
   assign result.is_command = held_type_in;

   // State update once per accepted interval.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_level_ff   <= 1'b0;
         bit_count_ff    <= '0;
         half_count_ff   <= 2'd0;
         shift_word_ff   <= '0;
         type_pending_ff <= 1'b0;
         parity_acc_ff   <= 1'b0;
         in_word_ff      <= 1'b0;
         held_word_ff    <= '0;
         held_type_ff    <= 1'b0;
      end else if (step_en) begin
         line_level_ff   <= line_level_in;
         bit_count_ff    <= bit_count_in;
         half_count_ff   <= half_count_in;
         shift_word_ff   <= shift_word_in;
         type_pending_ff <= type_pending_in;
         parity_acc_ff   <= parity_acc_in;
         in_word_ff      <= in_word_in;
         held_word_ff    <= held_word_in;
         held_type_ff    <= held_type_in;
      end
   end

endmodule

FILE: design/manchester_interval_word_decoder_top.sv
// Top level of the Manchester interval word decoder with its request and result registers.
//
// The decoder takes one line edge-to-edge interval per request, in percent of a bit period,
// and answers every request with exactly one result: a status code, the last completed
// 16-bit word and its command/data type. A sync pulse opens a word, sixteen full bit cells
// follow, and on the last half the parity is checked; a mismatch means reversed line
// polarity and inverts the word and its type. The user must write the parity seed
// (reset 1) through the configuration channel only while the decoder is idle; the block
// does not enforce this. Throughput is one request per clock while results are taken:
// the classification and state update form a single short pass from the request register
// to the result register. The request register takes a new request while a result
// waits to be taken, as long as it is itself empty.
module manchester_interval_word_decoder_top (
   input  logic       clock,
   input  logic       reset,
   mivd_req_if.sink   req_bus,
   mivd_rsp_if.source rsp_bus,
   mivd_csr_if.sink   csr_bus
);

   logic                           parity_seed_ff, parity_seed_in;
   logic                           in_valid_ff,    in_valid_in;
   logic [mivd_pkg::IntervalW-1:0] in_interval_ff, in_interval_in;
   logic                           out_valid_ff,   out_valid_in;
   mivd_pkg::result_type           out_result_ff,  out_result_in;
   mivd_pkg::result_type           step_result;
   logic                           advance;
   logic                           req_take;

   // Configuration register, always ready.
   assign csr_bus.ready  = 1'b1;
   assign parity_seed_in = (csr_bus.valid) ? csr_bus.parity_seed : parity_seed_ff;

   // Handshakes between the request register and the result register.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign in_valid_in    = req_take || (in_valid_ff && !advance);
   assign in_interval_in = req_take ? req_bus.interval_pct : in_interval_ff;
   assign out_valid_in   = advance || (out_valid_ff && !rsp_bus.ready);
   assign out_result_in  = advance ? step_result : out_result_ff;

   // Decode logic and state.
   mivd_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .interval_pct (in_interval_ff),
      .parity_seed  (parity_seed_ff),
      .result       (step_result)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         parity_seed_ff <= 1'b1;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         parity_seed_ff <= parity_seed_in;
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_interval_ff <= in_interval_in;
      out_result_ff  <= out_result_in;
   end

   // Result channel outputs.
   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.status     = out_result_ff.status;
   assign rsp_bus.word_out   = out_result_ff.word_out;
   assign rsp_bus.is_command = out_result_ff.is_command;

endmodule

FILE: dv/mivd_checker.sv
// Request/result checker for the Manchester interval word decoder.
module mivd_checker
   import mivd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mivd_req_if  req_bus,
   mivd_rsp_if  rsp_bus,
   mivd_csr_if  csr_bus,
   output int   error_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the decoder state and its parity seed.
   logic                 seed_bit;
   logic                 level;
   logic [BitCntW-1:0]   bits_in;
   int                   halves_seen;
   logic [WORD_BITS-1:0] word_shift;
   logic                 type_next;
   logic                 parity_run;
   logic                 word_open;
   logic [WORD_BITS-1:0] last_word;
   logic                 last_type;

   // Results predicted for accepted requests, oldest first.
   result_type expected_q[$];

   function automatic result_type status_result(status_code_type code);
      result_type r;
      r.status     = code;
      r.word_out   = WordOutW'(last_word);
      r.is_command = last_type;
      return r;
   endfunction

   function automatic void close_word();
      bits_in     = '0;
      halves_seen = 0;
      word_open   = 1'b0;
   endfunction

   // Predict the result of one interval and advance the shadow state.
   function automatic result_type decode_interval(logic [IntervalW-1:0] len);
      int halves;
      level = ~level;

      // Interval outside every class drops any word in progress.
      if (len <= LenMinExcl || len > LenMax) begin
         close_word();
         return status_result(ST_ERR_LEN);
      end

      if (len <= HalfMax) begin
         halves = halves_seen + 1;
      end else if (len <= FullMax) begin
         halves = halves_seen + 2;
      end else begin
         // A sync pulse opens a new word; its type comes from the level.
         word_open  = 1'b1;
         word_shift = '0;
         parity_run = seed_bit;
         bits_in    = '0;
         halves     = (len <= SyncShortMax) ? 1 : 2;
         type_next  = ~level;
      end

      // Three half bits in a row cannot occur in a valid cell.
      if (halves >= 3) begin
         close_word();
         return status_result(ST_ERR_STRUCT);
      end
      halves_seen = halves;

      if (!word_open) return status_result(ST_WAIT);

      if (halves_seen == 2) begin
         if (bits_in < WordBitsCnt) begin
            word_shift  = {word_shift[WORD_BITS-2:0], level};
            parity_run ^= level;
            bits_in++;
            halves_seen = 0;
         end else begin
            // Final half: a parity mismatch means the line polarity is reversed.
            last_word  = word_shift;
            last_type  = type_next;
            word_shift = '0;
            type_next  = 1'b0;
            close_word();
            if (level != parity_run) begin
               level     = ~level;
               last_word = ~last_word;
               last_type = ~last_type;
            end
            return status_result(ST_READY);
         end
      end
      return status_result((bits_in < WordBitsCnt) ? ST_HANDLE : ST_CHECK);
   endfunction

   // Watch all three channels; compare results before queueing new requests.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         seed_bit    = 1'b1;
         level       = 1'b0;
         bits_in     = '0;
         halves_seen = 0;
         word_shift  = '0;
         type_next   = 1'b0;
         parity_run  = 1'b0;
         word_open   = 1'b0;
         last_word   = '0;
         last_type   = 1'b0;
         error_count = 0;
         expected_q.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_q.size() == 0) begin
               error_count++;
               $display("%0t: result with no request pending: status %0d word %h type %b",
                        $time, rsp_bus.status, rsp_bus.word_out, rsp_bus.is_command);
            end else begin
               want = expected_q.pop_front();
               if (rsp_bus.status !== want.status) begin
                  error_count++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_bus.status);
               end
               if (rsp_bus.word_out !== want.word_out) begin
                  error_count++;
                  $display("%0t: word_out expected %h actual %h",
                           $time, want.word_out, rsp_bus.word_out);
               end
               if (rsp_bus.is_command !== want.is_command) begin
                  error_count++;
                  $display("%0t: is_command expected %b actual %b",
                           $time, want.is_command, rsp_bus.is_command);
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) seed_bit = csr_bus.parity_seed;
         if (req_bus.valid && req_bus.ready)
            expected_q.push_back(decode_interval(req_bus.interval_pct));
      end
      pending_count <= expected_q.size();
   end

endmodule

FILE: dv/tb_top.sv
// Testbench top: clock, reset, request and seed stimulus, and the final verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mivd_pkg::*;

   localparam int StallLimit  = 2000;
   localparam int PhaseCount  = 6;
   localparam int PhaseLength = 290;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_count;
   int   sent_count;
   int   quiet_cycles;
   int   rsp_stall_left;
   bit   no_idle;

   mivd_req_if req_if();
   mivd_rsp_if rsp_if();
   mivd_csr_if csr_if();

   manchester_interval_word_decoder_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   mivd_checker decode_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_if),
      .rsp_bus       (rsp_if),
      .csr_bus       (csr_if),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result side backpressure: short random stalls, none in the final phase.
   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp_if.ready   <= 1'b1;
         rsp_stall_left <= 0;
      end else if (rsp_stall_left > 0) begin
         rsp_if.ready   <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_if.ready   <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Watchdog: end the run if no channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Present one interval request, with an occasional idle gap before it.
   task automatic send_interval(input logic [IntervalW-1:0] len);
      int gap;
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.interval_pct <= len;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_count++;
   endtask

   // Interval within a class, leaning on the class boundaries.
   function automatic logic [IntervalW-1:0] pick_interval(int lo, int hi);
      case ($urandom_range(0, 7))
         0:       return IntervalW'(lo);
         1:       return IntervalW'(hi);
         default: return IntervalW'($urandom_range(lo, hi));
      endcase
   endfunction

   // One piece of a word; now and then a random interval breaks the sequence.
   task automatic send_word_part(input int lo, input int hi);
      if ($urandom_range(0, 79) == 0) send_interval(IntervalW'($urandom));
      else send_interval(pick_interval(lo, hi));
   endtask

   // A well-formed word: sync, then data cells, the final parity cell and one trailing cell.
   task automatic send_word();
      if ($urandom_range(0, 1)) begin
         send_word_part(FullMax + 1, SyncShortMax);
         send_word_part(LenMinExcl + 1, HalfMax);
      end else begin
         send_word_part(SyncShortMax + 1, LenMax);
      end
      repeat (WORD_BITS + 1) begin
         if ($urandom_range(0, 1)) begin
            send_word_part(HalfMax + 1, FullMax);
         end else begin
            send_word_part(LenMinExcl + 1, HalfMax);
            send_word_part(LenMinExcl + 1, HalfMax);
         end
      end
   endtask

   // Write the parity seed while the decoder is idle.
   task automatic write_seed(input logic seed);
      csr_if.valid       <= 1'b1;
      csr_if.parity_seed <= seed;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Stop requesting and wait until every result has been taken.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      logic [IntervalW-1:0] edge_cases[$];
      int                   target;
      req_if.valid        <= 1'b0;
      req_if.interval_pct <= '0;
      csr_if.valid        <= 1'b0;
      csr_if.parity_seed  <= 1'b0;
      reset               <= 1'b1;
      no_idle              = 1'b0;
      sent_count           = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: class boundaries, field extremes, structure errors, syncs.
      edge_cases = '{'0, '1, LenMinExcl, IntervalW'(LenMax + 1), IntervalW'(LenMinExcl + 1),
                     HalfMax, IntervalW'(HalfMax + 1), FullMax, HalfMax,
                     IntervalW'(FullMax + 1), SyncShortMax, IntervalW'(SyncShortMax + 1),
                     LenMax};
      foreach (edge_cases[i]) send_interval(edge_cases[i]);
      // The long sync above holds one bit; fifteen more cells and the parity cell.
      for (int i = 0; i < WORD_BITS; i++)
         send_interval((i % 2) ? FullMax : IntervalW'(HalfMax + 1));
      drain();

      // Random phases, each under its own parity seed; the last runs with no idling.
      for (int phase = 0; phase < PhaseCount; phase++) begin
         if (phase == 0) write_seed(1'b0);
         else if (phase == 1) write_seed(1'b1);
         else write_seed(1'($urandom_range(0, 1)));
         no_idle = (phase == PhaseCount - 1);
         target  = sent_count + PhaseLength;
         while (sent_count < target) begin
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 3)) send_interval(IntervalW'($urandom));
            end else begin
               send_word();
            end
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
